// ===== src/whtc_pkg.sv =====
`default_nettype none

package whtc_pkg;

	// register map
	typedef enum logic [2:0] {
		REG_WPM        = 3'd0,
		REG_CLAUSE     = 3'd1,
		REG_SENTENCE   = 3'd2,
		REG_PARAGRAPH  = 3'd3,
		REG_CHAR_BONUS = 3'd4,
		REG_NUMERIC    = 3'd5,
		REG_MAX_HOLD   = 3'd6,
		REG_MIN_HOLD   = 3'd7
	} whtc_reg_t;

	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [7:0]  LENGTH_BASELINE = 8'd6;
	localparam logic [15:0] MS_PER_MINUTE   = 16'd60000;
	localparam logic [9:0]  BASE_PCT        = 10'd100;

	localparam logic [10:0] WPM_RESET        = 11'd300;
	localparam logic [9:0]  CLAUSE_RESET     = 10'd150;
	localparam logic [9:0]  SENTENCE_RESET   = 10'd200;
	localparam logic [9:0]  PARAGRAPH_RESET  = 10'd260;
	localparam logic [7:0]  CHAR_BONUS_RESET = 8'd10;
	localparam logic [9:0]  NUMERIC_RESET    = 10'd150;
	localparam logic [15:0] MAX_HOLD_RESET   = 16'd2000;
	localparam logic [15:0] MIN_HOLD_RESET   = 16'd100;

	// base hold for the reset speed, so no division is needed after reset
	localparam int unsigned BASE_HOLD_RESET_I = 60000 / 300;
	localparam logic [15:0] BASE_HOLD_RESET   = 16'(BASE_HOLD_RESET_I);

	// x / 100 as (x * RECIP) >> RECIP_SHIFT, exact for x < 2^23
	localparam int unsigned RECIP_SHIFT = 30;
	localparam int unsigned RECIP_I     = ((1 << RECIP_SHIFT) + 99) / 100;
	localparam logic [23:0] RECIP       = 24'(RECIP_I);

endpackage

`default_nettype wire

// ===== src/word_hold_time_calc_top.sv =====
// Channel   | Ports                                         | Transaction
// ----------+-----------------------------------------------+------------------------
// token in  | start, busy, clause_end, sentence_end,        | edge with start && !busy
//           | paragraph_end, is_numeric, token_length       |
// hold out  | done, hold_ms                                 | every cycle done is high
// config    | cfg_we, cfg_index, cfg_data                   | every edge with cfg_we
//
// One token a cycle while busy is low; hold_ms appears with done once the token has
// passed a six-stage pipeline: pause/length terms, bonus multiply, sum,
// base multiply, reciprocal divide by 100 with ceiling test, then clamp.
// A write to words_per_minute starts a bit-serial divider; busy is high while it
// runs. After reset busy is low and the base hold is ready at once.
// The receiver cannot stall: every result is shown for exactly one cycle.
`default_nettype none

module word_hold_time_calc_top import whtc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  clause_end,
	input  wire logic                  sentence_end,
	input  wire logic                  paragraph_end,
	input  wire logic                  is_numeric,
	input  wire logic [7:0]            token_length,
	output logic                       done,
	output logic [15:0]                hold_ms,
	input  wire logic                  cfg_we,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [10:0] wpm_q;
	logic [9:0]  clause_q;
	logic [9:0]  sentence_q;
	logic [9:0]  paragraph_q;
	logic [7:0]  bonus_q;
	logic [9:0]  numeric_q;
	logic [15:0] max_hold_q;
	logic [15:0] min_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpm_q       <= WPM_RESET;
			clause_q    <= CLAUSE_RESET;
			sentence_q  <= SENTENCE_RESET;
			paragraph_q <= PARAGRAPH_RESET;
			bonus_q     <= CHAR_BONUS_RESET;
			numeric_q   <= NUMERIC_RESET;
			max_hold_q  <= MAX_HOLD_RESET;
			min_hold_q  <= MIN_HOLD_RESET;
		end else if (cfg_we) begin
			unique case (whtc_reg_t'(cfg_index))
				REG_WPM:        wpm_q       <= cfg_data[10:0];
				REG_CLAUSE:     clause_q    <= cfg_data[9:0];
				REG_SENTENCE:   sentence_q  <= cfg_data[9:0];
				REG_PARAGRAPH:  paragraph_q <= cfg_data[9:0];
				REG_CHAR_BONUS: bonus_q     <= cfg_data[7:0];
				REG_NUMERIC:    numeric_q   <= cfg_data[9:0];
				REG_MAX_HOLD:   max_hold_q  <= cfg_data[15:0];
				REG_MIN_HOLD:   min_hold_q  <= cfg_data[15:0];
				default:        wpm_q       <= wpm_q;
			endcase
		end
	end

	logic        div_go;
	logic        div_busy;
	logic [15:0] base_hold;

	assign div_go = cfg_we && (whtc_reg_t'(cfg_index) == REG_WPM);

	whtc_base_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.divisor  (cfg_data[10:0]),
		.busy     (div_busy),
		.quotient (base_hold)
	);

	// wpm_q is kept for its own sake; the divider latches the new value itself
	logic wpm_zero;
	assign wpm_zero = (wpm_q == 11'd0);

	assign busy = div_busy;

	logic accept;
	assign accept = start && !div_busy;

	// stage 1: boundary pause, length excess, numeric excess
	logic [9:0] pause_c;
	logic [7:0] excess_c;
	logic [9:0] digits_c;

	always_comb begin
		pause_c = BASE_PCT;
		if (clause_end && clause_q > pause_c) begin
			pause_c = clause_q;
		end
		if (sentence_end && sentence_q > pause_c) begin
			pause_c = sentence_q;
		end
		if (paragraph_end && paragraph_q > pause_c) begin
			pause_c = paragraph_q;
		end
		excess_c = (token_length > LENGTH_BASELINE) ? token_length - LENGTH_BASELINE : 8'd0;
		digits_c = (is_numeric && numeric_q > BASE_PCT) ? numeric_q - BASE_PCT : 10'd0;
	end

	logic       v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [9:0] pause_s1, pause_s2;
	logic [7:0] excess_s1;
	logic [9:0] digits_s1, digits_s2;
	logic [15:0] lenpct_s2;
	logic [16:0] pct_s3;
	logic [32:0] prod_s4;
	logic        over_s5;
	logic [15:0] quot_s5;
	logic [15:0] hold_s6;

	// stage 5 and stage 6 helpers
	logic [22:0] limit_c;
	logic [46:0] recip_prod_c;
	logic [15:0] hold_c;

	always_comb begin
		limit_c      = 23'(max_hold_q) * 23'd100 + 23'd100;
		recip_prod_c = 47'(prod_s4[22:0]) * 47'(RECIP);
		hold_c       = over_s5 ? max_hold_q : quot_s5;
		if (hold_c < min_hold_q) begin
			hold_c = min_hold_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pause_s1  <= pause_c;
			excess_s1 <= excess_c;
			digits_s1 <= digits_c;
		end
		if (v_s1) begin
			pause_s2  <= pause_s1;
			digits_s2 <= digits_s1;
			lenpct_s2 <= 16'(excess_s1) * 16'(bonus_q);
		end
		if (v_s2) begin
			pct_s3 <= 17'(pause_s2) + 17'(lenpct_s2) + 17'(digits_s2);
		end
		if (v_s3) begin
			prod_s4 <= 33'(base_hold) * 33'(pct_s3);
		end
		if (v_s4) begin
			// anything at or past (max+1)*100 clamps; below it the product fits 23 bits
			over_s5 <= prod_s4 >= 33'(limit_c);
			quot_s5 <= recip_prod_c[RECIP_SHIFT+15:RECIP_SHIFT];
		end
		if (v_s5) begin
			hold_s6 <= hold_c;
		end
	end

	assign done    = v_s6;
	assign hold_ms = hold_s6;

	// a zero speed never reaches the base register as a divisor of zero
	property p_no_zero_speed_div;
		@(posedge clk) disable iff (!arst_n)
		$fell(div_busy) && wpm_zero |-> base_hold == MS_PER_MINUTE;
	endproperty

	a_no_zero_speed_div: assert property (p_no_zero_speed_div)
		else $error("zero speed did not give the full-minute base hold");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##6 done)
		else $error("accepted token gave no result six cycles later");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 6))
		else $error("result with no matching token");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(div_busy) && !div_go |=> ##14 div_busy)
		else $error("base divider finished early");

endmodule

`default_nettype wire

// ===== src/whtc_base_div.sv =====
`default_nettype none

// 60000 / divisor (a zero divisor counts as one), restoring division, one quotient bit per cycle
module whtc_base_div import whtc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        go,
	input  wire logic [10:0] divisor,
	output logic             busy,
	output logic [15:0]      quotient
);

	logic        busy_q;
	logic [3:0]  cnt_q;
	logic [10:0] rem_q;
	logic [10:0] dsr_q;
	logic [15:0] dvd_q;
	logic [15:0] quot_q;

	logic [11:0] shifted;
	logic        qbit;
	logic [10:0] rem_next;

	always_comb begin
		shifted = {rem_q, dvd_q[15]};
		qbit    = shifted >= {1'b0, dsr_q};
		if (qbit) begin
			rem_next = 11'(shifted - {1'b0, dsr_q});
		end else begin
			rem_next = shifted[10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			quot_q <= BASE_HOLD_RESET;
		end else if (go) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
				quot_q <= {dvd_q[14:0], qbit};
			end
		end
	end

	// datapath: the dividend register fills with quotient bits as it empties
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvd_q <= MS_PER_MINUTE;
			dsr_q <= (divisor == 11'd0) ? 11'd1 : divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[14:0], qbit};
		end
	end

	assign busy     = busy_q;
	assign quotient = quot_q;

endmodule

`default_nettype wire

// ===== sim/word_hold_time_calc_checker.sv =====
module word_hold_time_calc_checker import whtc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire logic                  clause_end,
	input  wire logic                  sentence_end,
	input  wire logic                  paragraph_end,
	input  wire logic                  is_numeric,
	input  wire logic [7:0]            token_length,
	input  wire logic                  done,
	input  wire logic [15:0]           hold_ms,
	input  wire logic                  cfg_we,
	input  wire logic [2:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output int                         fail_count,
	output int                         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        clause;
		logic        sentence;
		logic        paragraph;
		logic        numeric;
		logic [7:0]  len;
		logic [15:0] hold;
	} hold_txn_t;

	hold_txn_t expected_holds[$];

	// shadow of the register file
	logic [10:0] wpm;
	logic [9:0]  clause_pct;
	logic [9:0]  sentence_pct;
	logic [9:0]  paragraph_pct;
	logic [7:0]  char_bonus;
	logic [9:0]  numeric_pct;
	logic [15:0] max_hold;
	logic [15:0] min_hold;

	initial fail_count = 0;

	function automatic logic [15:0] predict_hold(logic c, logic s, logic p, logic n,
			logic [7:0] len);
		longint unsigned speed;
		longint unsigned base;
		longint unsigned pct;
		longint unsigned hold;
		speed = (wpm == '0) ? 64'd1 : 64'(wpm);
		base  = 64'(MS_PER_MINUTE) / speed;
		// largest boundary pause wins, never below 100
		pct = 64'(BASE_PCT);
		if (c && 64'(clause_pct) > pct)
			pct = 64'(clause_pct);
		if (s && 64'(sentence_pct) > pct)
			pct = 64'(sentence_pct);
		if (p && 64'(paragraph_pct) > pct)
			pct = 64'(paragraph_pct);
		if (len > LENGTH_BASELINE)
			pct = pct + (64'(len) - 64'(LENGTH_BASELINE)) * 64'(char_bonus);
		if (n && numeric_pct > BASE_PCT)
			pct = pct + 64'(numeric_pct) - 64'(BASE_PCT);
		hold = (base * pct) / 64'(BASE_PCT);
		if (hold > 64'(max_hold))
			hold = 64'(max_hold);
		if (hold < 64'(min_hold))
			hold = 64'(min_hold);
		return hold[15:0];
	endfunction

	task automatic report_mismatch(string what, hold_txn_t want, logic [15:0] got);
		$display("hold check: %s: c %0b s %0b p %0b n %0b len %0d want %0d got %0d",
			what, want.clause, want.sentence, want.paragraph, want.numeric, want.len,
			want.hold, got);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		hold_txn_t txn;
		if (!arst_n) begin
			wpm           <= WPM_RESET;
			clause_pct    <= CLAUSE_RESET;
			sentence_pct  <= SENTENCE_RESET;
			paragraph_pct <= PARAGRAPH_RESET;
			char_bonus    <= CHAR_BONUS_RESET;
			numeric_pct   <= NUMERIC_RESET;
			max_hold      <= MAX_HOLD_RESET;
			min_hold      <= MIN_HOLD_RESET;
			expected_holds.delete();
			outstanding   <= 0;
		end else begin
			// results are popped before this edge's token is pushed
			if (done) begin
				if (expected_holds.size() == 0) begin
					txn = '0;
					report_mismatch("result with no token waiting", txn, hold_ms);
				end else begin
					txn = expected_holds.pop_front();
					if (hold_ms !== txn.hold)
						report_mismatch("wrong hold_ms", txn, hold_ms);
				end
			end
			if (start && !busy) begin
				txn.clause    = clause_end;
				txn.sentence  = sentence_end;
				txn.paragraph = paragraph_end;
				txn.numeric   = is_numeric;
				txn.len       = token_length;
				txn.hold      = predict_hold(clause_end, sentence_end, paragraph_end,
					is_numeric, token_length);
				expected_holds.push_back(txn);
			end
			if (cfg_we) begin
				case (whtc_reg_t'(cfg_index))
					REG_WPM:        wpm           <= cfg_data[10:0];
					REG_CLAUSE:     clause_pct    <= cfg_data[9:0];
					REG_SENTENCE:   sentence_pct  <= cfg_data[9:0];
					REG_PARAGRAPH:  paragraph_pct <= cfg_data[9:0];
					REG_CHAR_BONUS: char_bonus    <= cfg_data[7:0];
					REG_NUMERIC:    numeric_pct   <= cfg_data[9:0];
					REG_MAX_HOLD:   max_hold      <= cfg_data[15:0];
					REG_MIN_HOLD:   min_hold      <= cfg_data[15:0];
					default: ;
				endcase
			end
			outstanding <= expected_holds.size();
		end
	end

endmodule

// ===== sim/word_hold_time_calc_top_tb.sv =====
module word_hold_time_calc_top_tb;
	import whtc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TOKENS_PER_PHASE = 94;
	localparam int PHASES = 11;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  clause_end = 1'b0;
	logic                  sentence_end = 1'b0;
	logic                  paragraph_end = 1'b0;
	logic                  is_numeric = 1'b0;
	logic [7:0]            token_length = '0;
	logic                  cfg_we = 1'b0;
	logic [2:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	wire logic             busy;
	wire logic             done;
	wire logic [15:0]      hold_ms;
	int                    fail_count;
	int                    outstanding;
	int                    cycles = 0;
	bit                    steady = 1'b0;

	word_hold_time_calc_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.clause_end    (clause_end),
		.sentence_end  (sentence_end),
		.paragraph_end (paragraph_end),
		.is_numeric    (is_numeric),
		.token_length  (token_length),
		.done          (done),
		.hold_ms       (hold_ms),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	word_hold_time_calc_checker u_hold_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.clause_end    (clause_end),
		.sentence_end  (sentence_end),
		.paragraph_end (paragraph_end),
		.is_numeric    (is_numeric),
		.token_length  (token_length),
		.done          (done),
		.hold_ms       (hold_ms),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.outstanding   (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// holds start until the transaction is taken; busy read here is the pre-edge value
	task automatic send_token(logic c, logic s, logic p, logic n, logic [7:0] len);
		while (!steady && $urandom_range(99) < 8) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start         <= 1'b1;
		clause_end    <= c;
		sentence_end  <= s;
		paragraph_end <= p;
		is_numeric    <= n;
		token_length  <= len;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_random_token();
		logic [7:0] len;
		len = ($urandom_range(9) < 6) ? 8'($urandom_range(15)) : 8'($urandom);
		send_token($urandom_range(2) == 0, $urandom_range(2) == 0, $urandom_range(3) == 0,
			$urandom_range(2) == 0, len);
	endtask

	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0 || busy);
	endtask

	// speed goes last, as its write sets off the divider
	task automatic write_config(input logic [15:0] vals [8]);
		whtc_reg_t idx;
		settle();
		for (int i = 1; i <= 8; i++) begin
			idx = whtc_reg_t'(i % 8);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[idx];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [15:0] rand_reg(int unsigned hi);
		if ($urandom_range(7) == 0)
			return 16'($urandom);
		return 16'($urandom_range(hi));
	endfunction

	initial begin : stimulus
		logic [15:0] cfg [8];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: every flag mix, lengths across the range and round the baseline
		for (int f = 0; f < 16; f++)
			send_token(f[0], f[1], f[2], f[3], 8'(f * 17));
		send_token(1'b0, 1'b0, 1'b0, 1'b0, 8'd6);
		send_token(1'b0, 1'b0, 1'b0, 1'b1, 8'd7);
		send_token(1'b1, 1'b1, 1'b1, 1'b1, 8'd255);
		send_token(1'b0, 1'b0, 1'b0, 1'b0, 8'd0);

		for (int ph = 1; ph <= PHASES; ph++) begin
			case (ph)
				// zero speed, pauses under 100, numeric at exactly 100
				1: cfg = '{16'd0, 16'd50, 16'd40, 16'd30, 16'd255, 16'd100, 16'd65535, 16'd0};
				2: cfg = '{16'd2000, 16'd1023, 16'd1023, 16'd1023, 16'd255, 16'd1023,
					16'd65535, 16'd0};
				// ceiling below floor
				3: cfg = '{16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd500, 16'd900};
				4: cfg = '{default: 16'd0};
				// every data bit set: only each register's low bits stick
				5: cfg = '{default: 16'hFFFF};
				default: begin
					cfg[REG_WPM]        = ($urandom_range(3) == 0) ?
						16'($urandom_range(20)) : rand_reg(2000);
					cfg[REG_CLAUSE]     = rand_reg(1023);
					cfg[REG_SENTENCE]   = rand_reg(1023);
					cfg[REG_PARAGRAPH]  = rand_reg(1023);
					cfg[REG_CHAR_BONUS] = rand_reg(255);
					cfg[REG_NUMERIC]    = rand_reg(1023);
					cfg[REG_MAX_HOLD]   = 16'($urandom_range(65535));
					cfg[REG_MIN_HOLD]   = rand_reg(400);
				end
			endcase
			write_config(cfg);
			steady = (ph == 6);
			repeat (TOKENS_PER_PHASE)
				send_random_token();
		end

		settle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
